@@ sv/explicit_free_list_heap_allocator_top_defines.svh @@
// Assertion macros shared by the allocator checkers.
// Depends on nothing; every user provides clock and reset signals.
`ifndef EXPLICIT_FREE_LIST_HEAP_ALLOCATOR_TOP_DEFINES_SVH
`define EXPLICIT_FREE_LIST_HEAP_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define EFLA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define EFLA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/efla_pkg.sv @@
// Shared types, codes and constants of the free-list heap allocator.
// Depends on nothing; used by every module of the allocator.
package efla_pkg;

   localparam int unsigned HEAP_WORDS_DEF = 16384;
   localparam logic [16:0] CHUNK_RESET    = 17'd4096;

   // Request operation codes.
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // Result status codes.
   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_OOM  = 2'd2;
   localparam logic [1:0] ST_NULL = 2'd3;

   typedef struct packed {
      logic        func;
      logic [15:0] req_size;
      logic [15:0] block_addr;
   } req_type;

   typedef struct packed {
      logic [15:0] payload_addr;
      logic [1:0]  status;
   } rsp_type;

   // One access to the heap store: a read or a write at a byte address.
   typedef struct packed {
      logic        rd_en;
      logic        wr_en;
      logic [31:0] addr;
      logic [31:0] wdata;
   } mem_req_type;

   typedef enum logic [5:0] {
      S_CLEAR, S_IDLE,
      S_W_TEST, S_W_SIZE, S_W_LINK,
      S_G_CHECK, S_G_W0, S_G_W1, S_G_W2, S_G_W3, S_G_W4,
      S_P_RD, S_P_CS, S_P_DEC, S_P_T0, S_P_T1, S_P_NRD, S_P_NX,
      S_P_R0, S_P_R1, S_P_R2, S_P_R3, S_P_F0, S_P_F1,
      S_R_RD, S_R_SZ, S_R_T1, S_R_Z0, S_R_Z1,
      S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
      S_MA0, S_MA1, S_MA2,
      S_MB0, S_MB1, S_MB2, S_MB3,
      S_MC_U2, S_MC0, S_MC1, S_MC2, S_MC3, S_MC4, S_MC5,
      S_M_ROV, S_M_RV1,
      S_PH0, S_PH1, S_PH2,
      S_U0, S_U1, S_U2, S_U3, S_U4, S_U5,
      S_FIN
   } ctrl_state_type;

endpackage

@@ sv/efla_mem.sv @@
// Heap word store: one synchronous access port, read data registered.
// Depends on efla_pkg for the access struct.
module efla_mem #(
   parameter int unsigned HEAP_WORDS = efla_pkg::HEAP_WORDS_DEF
) (
   input  logic                  clock,
   input  efla_pkg::mem_req_type mem_req,
   output logic [31:0]           rdata_ff
);
   import efla_pkg::*;

   localparam int unsigned AW = $clog2(HEAP_WORDS);

   logic [31:0] heap_mem [HEAP_WORDS];
   logic [AW-1:0] idx;

   // Byte addresses wrap around the store.
   assign idx = mem_req.addr[AW+1:2];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         heap_mem[idx] <= mem_req.wdata;
      end
      if (mem_req.rd_en) begin
         rdata_ff <= heap_mem[idx];
      end
   end

endmodule

@@ sv/efla_ctrl.sv @@
// Allocator sequencer: list search, growth, split, coalesce and list upkeep.
// Depends on efla_pkg; drives the single port of efla_mem.
module efla_ctrl #(
   parameter int unsigned HEAP_WORDS = efla_pkg::HEAP_WORDS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  efla_pkg::req_type     req_data,
   input  logic [16:0]           chunk_bytes,
   output logic                  fin_valid,
   input  logic                  fin_ready,
   output efla_pkg::rsp_type     fin_data,
   output efla_pkg::mem_req_type mem_req,
   input  logic [31:0]           mem_rdata
);
   import efla_pkg::*;

   localparam int unsigned AW         = $clog2(HEAP_WORDS);
   localparam int unsigned CAP        = HEAP_WORDS * 4;
   localparam int unsigned INIT_B     = (CAP < 4112) ? ((CAP - 16) / 8) * 8 : 4096;
   localparam int unsigned INIT_FTR_W = (INIT_B + 8) / 4;
   localparam int unsigned INIT_EPI_W = (INIT_B + 12) / 4;
   localparam int unsigned LIMIT      = HEAP_WORDS / 4 + 1;
   localparam int unsigned STEP_W     = $clog2(LIMIT + 1);

   ctrl_state_type state_ff, state_in, ret_ff, ret_in;
   logic [AW-1:0]  clr_idx_ff, clr_idx_in;
   logic [31:0]    brk_ff, brk_in, head_ff, head_in, rover_ff, rover_in;
   logic [31:0]    bp_ff, bp_in, sz_ff, sz_in, csize_ff, csize_in;
   logic [31:0]    pp_ff, pp_in, nn_ff, nn_in, tmp_ff, tmp_in;
   logic [31:0]    ux_ff, ux_in, us_ff, us_in, up_ff, up_in;
   logic [16:0]    asize_ff, asize_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic           pass2_ff, pass2_in, pa_ff, pa_in, hit_ff, hit_in;
   logic           mp_put_ff, mp_put_in;
   logic [15:0]    pay_ff, pay_in;
   logic [1:0]     st_ff, st_in;

   logic [31:0] dm, asz32;
   logic [16:0] ext;
   logic [15:0] words;
   logic [17:0] grow_b;
   logic        req_fire;

   assign dm       = mem_rdata & ~32'd7;
   assign asz32    = {15'd0, asize_ff};
   assign ext      = (asize_ff > chunk_bytes) ? asize_ff : chunk_bytes;
   assign words    = {1'b0, ext[16:2]} + {15'd0, ext[2]};
   assign grow_b   = {words, 2'b00};
   assign req_fire = req_valid && req_ready;

   // Initial store image written by the clearing pass.
   function automatic logic [31:0] clr_word(input logic [AW-1:0] idx);
      logic [31:0] v;
      v = '0;
      if (idx == AW'(1) || idx == AW'(2)) v = 32'd9;
      if (idx == AW'(3)) v = 32'(INIT_B);
      if (idx == AW'(INIT_FTR_W)) v = 32'(INIT_B);
      if (idx == AW'(INIT_EPI_W)) v = 32'd1;
      return v;
   endfunction

   function automatic mem_req_type rd_op(input logic [31:0] a);
      mem_req_type r;
      r = '0;
      r.rd_en = 1'b1;
      r.addr  = a;
      return r;
   endfunction

   function automatic mem_req_type wr_op(input logic [31:0] a, input logic [31:0] v);
      mem_req_type r;
      r = '0;
      r.wr_en = 1'b1;
      r.addr  = a;
      r.wdata = v;
      return r;
   endfunction

   // Next state and datapath register updates.
   always_comb begin
      state_in = state_ff;   ret_in = ret_ff;     clr_idx_in = clr_idx_ff;
      brk_in = brk_ff;       head_in = head_ff;   rover_in = rover_ff;
      bp_in = bp_ff;         sz_in = sz_ff;       csize_in = csize_ff;
      pp_in = pp_ff;         nn_in = nn_ff;       tmp_in = tmp_ff;
      ux_in = ux_ff;         us_in = us_ff;       up_in = up_ff;
      asize_in = asize_ff;   steps_in = steps_ff; pass2_in = pass2_ff;
      pa_in = pa_ff;         hit_in = hit_ff;     mp_put_in = mp_put_ff;
      pay_in = pay_ff;       st_in = st_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_idx_in = clr_idx_ff + AW'(1);
            if (clr_idx_ff == AW'(HEAP_WORDS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_fire) begin
               pay_in = '0;
               st_in  = ST_DONE;
               if (req_data.func == FUNC_FREE) begin
                  if (req_data.block_addr == 16'd0) begin
                     st_in    = ST_NULL;
                     state_in = S_FIN;
                  end else begin
                     bp_in     = {16'd0, req_data.block_addr};
                     mp_put_in = 1'b0;
                     state_in  = S_R_RD;
                  end
               end else if (req_data.req_size == 16'd0) begin
                  st_in    = ST_ZERO;
                  state_in = S_FIN;
               end else begin
                  asize_in = (req_data.req_size <= 16'd8) ? 17'd16 :
                             (({1'b0, req_data.req_size} + 17'd15) & ~17'd7);
                  if (rover_ff == '0) rover_in = head_ff;
                  pass2_in = 1'b0;
                  steps_in = '0;
                  state_in = S_W_TEST;
               end
            end
         end
         // Next-fit walk of the free list.
         S_W_TEST: begin
            if (rover_ff == '0 || steps_ff == STEP_W'(LIMIT)) begin
               if (rover_ff != '0) rover_in = '0;
               if (!pass2_ff) begin
                  pass2_in = 1'b1;
                  rover_in = head_ff;
                  steps_in = '0;
               end else begin
                  state_in = S_G_CHECK;
               end
            end else begin
               steps_in = steps_ff + STEP_W'(1);
               state_in = S_W_SIZE;
            end
         end
         S_W_SIZE: begin
            hit_in   = (asz32 <= dm);
            state_in = S_W_LINK;
         end
         S_W_LINK: begin
            rover_in = mem_rdata;
            if (hit_ff) begin
               bp_in    = rover_ff;
               state_in = S_P_RD;
            end else begin
               state_in = S_W_TEST;
            end
         end
         // Break growth.
         S_G_CHECK: begin
            if ({1'b0, brk_ff} + {15'd0, grow_b} > 33'(CAP)) begin
               st_in    = ST_OOM;
               state_in = S_FIN;
            end else begin
               bp_in    = brk_ff;
               brk_in   = brk_ff + {14'd0, grow_b};
               tmp_in   = {14'd0, grow_b};
               state_in = S_G_W0;
            end
         end
         S_G_W0: state_in = S_G_W1;
         S_G_W1: state_in = S_G_W2;
         S_G_W2: state_in = S_G_W3;
         S_G_W3: state_in = S_G_W4;
         S_G_W4: begin
            mp_put_in = 1'b1;
            state_in  = S_M0;
         end
         // Placement with optional split.
         S_P_RD: begin
            pay_in   = bp_ff[15:0];
            state_in = S_P_CS;
         end
         S_P_CS: begin
            csize_in = dm;
            ux_in    = bp_ff;
            ret_in   = S_P_DEC;
            state_in = S_U0;
         end
         S_P_DEC: begin
            if ((csize_ff - asz32) >= 32'd16 && csize_ff >= asz32) state_in = S_P_T0;
            else state_in = S_P_F0;
         end
         S_P_T0:  state_in = S_P_T1;
         S_P_T1:  state_in = S_P_NRD;
         S_P_NRD: state_in = S_P_NX;
         S_P_NX: begin
            bp_in    = bp_ff + dm;
            sz_in    = csize_ff - asz32;
            state_in = S_P_R0;
         end
         S_P_R0: state_in = S_P_R1;
         S_P_R1: state_in = S_P_R2;
         S_P_R2: state_in = S_P_R3;
         S_P_R3: begin
            mp_put_in = 1'b0;
            state_in  = S_M0;
         end
         S_P_F0: state_in = S_P_F1;
         S_P_F1: state_in = S_FIN;
         // Release: retag as free and clear links.
         S_R_RD: state_in = S_R_SZ;
         S_R_SZ: begin
            sz_in    = dm;
            state_in = S_R_T1;
         end
         S_R_T1: state_in = S_R_Z0;
         S_R_Z0: state_in = S_R_Z1;
         S_R_Z1: state_in = S_M0;
         // Coalescing with neighbors.
         S_M0: state_in = S_M1;
         S_M1: begin
            pp_in    = bp_ff - dm;
            state_in = S_M2;
         end
         S_M2: state_in = S_M3;
         S_M3: begin
            pa_in    = mem_rdata[0];
            state_in = S_M4;
         end
         S_M4: begin
            sz_in    = dm;
            nn_in    = bp_ff + dm;
            state_in = S_M5;
         end
         S_M5: begin
            if (pa_ff && mem_rdata[0]) begin
               state_in = S_M_ROV;
            end else if (pa_ff) begin
               ux_in    = nn_ff;
               ret_in   = S_MA0;
               state_in = S_U0;
            end else if (mem_rdata[0]) begin
               ux_in    = pp_ff;
               ret_in   = S_MB0;
               state_in = S_U0;
            end else begin
               ux_in    = pp_ff;
               ret_in   = S_MC_U2;
               state_in = S_U0;
            end
         end
         S_MA0: state_in = S_MA1;
         S_MA1: begin
            sz_in    = sz_ff + dm;
            state_in = S_MA2;
         end
         S_MA2: state_in = S_M_ROV;
         S_MB0: state_in = S_MB1;
         S_MB1: begin
            sz_in    = sz_ff + dm;
            state_in = S_MB2;
         end
         S_MB2: state_in = S_MB3;
         S_MB3: begin
            bp_in    = pp_ff;
            state_in = S_M_ROV;
         end
         S_MC_U2: begin
            ux_in    = nn_ff;
            ret_in   = S_MC0;
            state_in = S_U0;
         end
         S_MC0: state_in = S_MC1;
         S_MC1: begin
            tmp_in   = dm;
            state_in = S_MC2;
         end
         S_MC2: state_in = S_MC3;
         S_MC3: begin
            sz_in    = sz_ff + tmp_ff + dm;
            state_in = S_MC4;
         end
         S_MC4: state_in = S_MC5;
         S_MC5: begin
            bp_in    = pp_ff;
            state_in = S_M_ROV;
         end
         // Pull a rover that points inside the merged block to its start.
         S_M_ROV: state_in = S_M_RV1;
         S_M_RV1: begin
            if (rover_ff > bp_ff && rover_ff < bp_ff + dm) rover_in = bp_ff;
            state_in = S_PH0;
         end
         // Push on the list head.
         S_PH0: begin
            if (head_ff == '0) begin
               head_in  = bp_ff;
               state_in = mp_put_ff ? S_P_RD : S_FIN;
            end else begin
               state_in = S_PH1;
            end
         end
         S_PH1: state_in = S_PH2;
         S_PH2: begin
            head_in  = bp_ff;
            state_in = mp_put_ff ? S_P_RD : S_FIN;
         end
         // Unlink of the block at ux.
         S_U0: state_in = S_U1;
         S_U1: begin
            us_in    = mem_rdata;
            state_in = S_U2;
         end
         S_U2: begin
            up_in    = mem_rdata;
            state_in = S_U3;
         end
         S_U3: state_in = S_U4;
         S_U4: begin
            if (up_ff == '0) begin
               head_in  = us_ff;
               state_in = ret_ff;
            end else begin
               state_in = (us_ff != '0) ? S_U5 : ret_ff;
            end
         end
         S_U5: state_in = ret_ff;
         S_FIN: begin
            if (fin_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Store accesses and handshake outputs.
   always_comb begin
      mem_req   = '0;
      req_ready = 1'b0;
      fin_valid = 1'b0;
      unique case (state_ff)
         S_CLEAR: mem_req = wr_op({{(30 - AW){1'b0}}, clr_idx_ff, 2'b00}, clr_word(clr_idx_ff));
         S_IDLE:  req_ready = 1'b1;
         S_W_TEST: begin
            if (rover_ff != '0 && steps_ff != STEP_W'(LIMIT)) mem_req = rd_op(rover_ff - 32'd4);
         end
         S_W_SIZE: mem_req = rd_op(rover_ff);
         S_G_W0:  mem_req = wr_op(bp_ff - 32'd4, tmp_ff);
         S_G_W1:  mem_req = wr_op(bp_ff + tmp_ff - 32'd8, tmp_ff);
         S_G_W2:  mem_req = wr_op(bp_ff + tmp_ff - 32'd4, 32'd1);
         S_G_W3:  mem_req = wr_op(bp_ff, '0);
         S_G_W4:  mem_req = wr_op(bp_ff + 32'd4, '0);
         S_P_RD:  mem_req = rd_op(bp_ff - 32'd4);
         S_P_T0:  mem_req = wr_op(bp_ff - 32'd4, asz32 | 32'd1);
         S_P_T1:  mem_req = wr_op(bp_ff + asz32 - 32'd8, asz32 | 32'd1);
         S_P_NRD: mem_req = rd_op(bp_ff - 32'd4);
         S_P_R0:  mem_req = wr_op(bp_ff - 32'd4, sz_ff);
         S_P_R1:  mem_req = wr_op(bp_ff + sz_ff - 32'd8, sz_ff);
         S_P_R2:  mem_req = wr_op(bp_ff, '0);
         S_P_R3:  mem_req = wr_op(bp_ff + 32'd4, '0);
         S_P_F0:  mem_req = wr_op(bp_ff - 32'd4, csize_ff | 32'd1);
         S_P_F1:  mem_req = wr_op(bp_ff + csize_ff - 32'd8, csize_ff | 32'd1);
         S_R_RD:  mem_req = rd_op(bp_ff - 32'd4);
         S_R_SZ:  mem_req = wr_op(bp_ff - 32'd4, dm);
         S_R_T1:  mem_req = wr_op(bp_ff + sz_ff - 32'd8, sz_ff);
         S_R_Z0:  mem_req = wr_op(bp_ff, '0);
         S_R_Z1:  mem_req = wr_op(bp_ff + 32'd4, '0);
         S_M0:    mem_req = rd_op(bp_ff - 32'd8);
         S_M1:    mem_req = rd_op(bp_ff - dm - 32'd4);
         S_M2:    mem_req = rd_op(pp_ff + dm - 32'd8);
         S_M3:    mem_req = rd_op(bp_ff - 32'd4);
         S_M4:    mem_req = rd_op(bp_ff + dm - 32'd4);
         S_MA0:   mem_req = rd_op(nn_ff - 32'd4);
         S_MA1:   mem_req = wr_op(bp_ff - 32'd4, sz_ff + dm);
         S_MA2:   mem_req = wr_op(bp_ff + sz_ff - 32'd8, sz_ff);
         S_MB0:   mem_req = rd_op(pp_ff - 32'd4);
         S_MB1:   mem_req = rd_op(bp_ff - 32'd4);
         S_MB2:   mem_req = wr_op(bp_ff + dm - 32'd8, sz_ff);
         S_MB3:   mem_req = wr_op(pp_ff - 32'd4, sz_ff);
         S_MC0:   mem_req = rd_op(pp_ff - 32'd4);
         S_MC1:   mem_req = rd_op(nn_ff - 32'd4);
         S_MC2:   mem_req = rd_op(nn_ff + dm - 32'd8);
         S_MC3:   mem_req = wr_op(pp_ff - 32'd4, sz_ff + tmp_ff + dm);
         S_MC4:   mem_req = rd_op(nn_ff - 32'd4);
         S_MC5:   mem_req = wr_op(nn_ff + dm - 32'd8, sz_ff);
         S_M_ROV: mem_req = rd_op(bp_ff - 32'd4);
         S_PH0: begin
            if (head_ff != '0) mem_req = wr_op(bp_ff, head_ff);
         end
         S_PH1:   mem_req = wr_op(bp_ff + 32'd4, '0);
         S_PH2:   mem_req = wr_op(head_ff + 32'd4, bp_ff);
         S_U0:    mem_req = rd_op(ux_ff);
         S_U1:    mem_req = rd_op(ux_ff + 32'd4);
         S_U2:    mem_req = wr_op(ux_ff, '0);
         S_U3:    mem_req = wr_op(ux_ff + 32'd4, '0);
         S_U4: begin
            if (up_ff == '0) begin
               if (us_ff != '0) mem_req = wr_op(us_ff + 32'd4, '0);
            end else begin
               mem_req = wr_op(up_ff, us_ff);
            end
         end
         S_U5:    mem_req = wr_op(us_ff + 32'd4, up_ff);
         S_FIN:   fin_valid = 1'b1;
         default: mem_req = '0;
      endcase
   end

   assign fin_data.payload_addr = pay_ff;
   assign fin_data.status       = st_ff;

   // Control state and allocator registers with reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_idx_ff <= '0;
         brk_ff     <= 32'(16 + INIT_B);
         head_ff    <= 32'd16;
         rover_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         clr_idx_ff <= clr_idx_in;
         brk_ff     <= brk_in;
         head_ff    <= head_in;
         rover_ff   <= rover_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      ret_ff <= ret_in;       bp_ff <= bp_in;         sz_ff <= sz_in;
      csize_ff <= csize_in;   pp_ff <= pp_in;         nn_ff <= nn_in;
      tmp_ff <= tmp_in;       ux_ff <= ux_in;         us_ff <= us_in;
      up_ff <= up_in;         asize_ff <= asize_in;   steps_ff <= steps_in;
      pass2_ff <= pass2_in;   pa_ff <= pa_in;         hit_ff <= hit_in;
      mp_put_ff <= mp_put_in; pay_ff <= pay_in;       st_ff <= st_in;
   end

endmodule

@@ sv/explicit_free_list_heap_allocator_top.sv @@
// Free-list heap allocator: request, result and register channels.
// Each request word (req_data) is an allocate (func 0, req_size bytes) or a
// release (func 1, block_addr). Each gives one result word (rsp_data) with
// the payload offset and a status. csr_wdata sets chunk_bytes, the minimum
// heap growth, and is always ready; the user must write it only while idle.
// The block itself does not enforce this. A zero-size allocate or a null
// release goes straight to the result. An allocate walks the free list
// from the rover, reading each block visited, then splits and tags the
// chosen block, or first grows the heap and fails when it is full; a
// release retags, coalesces and relists the block via the single store port.
// One request is in work at a time; a new one is taken as soon as the
// previous result sits in the output register, even if rsp_ready is low.
// After reset the store is written with its initial image, one word per
// cycle through every word of the store, with req_ready low throughout.
// A stalled receiver holds the result in the output register; the next
// finished result waits in the sequencer until that register frees.
// HEAP_WORDS must be a power of two.
module explicit_free_list_heap_allocator_top #(
   parameter int unsigned HEAP_WORDS = efla_pkg::HEAP_WORDS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  efla_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output efla_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [16:0]       csr_wdata
);
   import efla_pkg::*;

   logic [16:0] chunk_bytes_ff, chunk_bytes_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        fin_valid, fin_ready;
   rsp_type     fin_data;
   mem_req_type mem_req;
   logic [31:0] mem_rdata;

   efla_ctrl #(.HEAP_WORDS(HEAP_WORDS)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .chunk_bytes (chunk_bytes_ff),
      .fin_valid   (fin_valid),
      .fin_ready   (fin_ready),
      .fin_data    (fin_data),
      .mem_req     (mem_req),
      .mem_rdata   (mem_rdata)
   );

   efla_mem #(.HEAP_WORDS(HEAP_WORDS)) u_mem (
      .clock    (clock),
      .mem_req  (mem_req),
      .rdata_ff (mem_rdata)
   );

   // Register write: always accepted.
   assign csr_ready      = 1'b1;
   assign chunk_bytes_in = (csr_valid && csr_ready) ? csr_wdata : chunk_bytes_ff;

   // Output register: loads when empty or being emptied.
   assign fin_ready    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = (fin_valid && fin_ready) || (rsp_valid_ff && !rsp_ready);
   assign rsp_data_in  = (fin_valid && fin_ready) ? fin_data : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_bytes_ff <= CHUNK_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         chunk_bytes_ff <= chunk_bytes_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ sv/efla_chk.sv @@
// Port-level checks of the heap allocator, bound to its top level.
// Depends on efla_pkg and the assertion macros header.
`include "explicit_free_list_heap_allocator_top_defines.svh"

module efla_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input efla_pkg::rsp_type rsp_data
);
   import efla_pkg::*;

   // The store image is written right after reset, so no request is taken.
   `EFLA_ASSERT_NOW(a_clear_busy, $past(reset), !req_ready, "request taken during clearing pass")

   // Only one request is worked on at a time.
   `EFLA_ASSERT_NEXT(a_one_inflight, req_valid && req_ready, !req_ready, "request taken while busy")

   // A stalled result word holds.
   `EFLA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // Every result other than a successful operation carries a null offset.
   `EFLA_ASSERT_NOW(a_fail_null, rsp_valid && rsp_data.status != ST_DONE, rsp_data.payload_addr == 16'd0, "failed result with nonzero offset")

endmodule

bind explicit_free_list_heap_allocator_top efla_chk u_efla_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ verif/heap_alloc_checker.sv @@
// Checker for the free-list heap allocator: keeps its own image of the heap,
// predicts each result word and compares it with the word the block returns.
// Depends on efla_pkg for the request and result types and the codes.
`timescale 1ns / 1ps

module heap_alloc_checker #(
   parameter int unsigned HEAP_WORDS = efla_pkg::HEAP_WORDS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  efla_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  efla_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [16:0]       csr_wdata,
   input  logic              end_check,
   output int                fail_count
);
   import efla_pkg::*;

   localparam int unsigned WALK_MAX = HEAP_WORDS / 4 + 1;

   // Shadow copy of the heap and its bookkeeping.
   bit [31:0]   heap_mem [HEAP_WORDS];
   int unsigned brk_ofs;
   int unsigned list_head;
   int unsigned rover_ofs;
   int unsigned chunk_min;
   rsp_type     expected_rsp [$];
   bit          end_seen;

   function automatic int unsigned rd(int unsigned a);
      return heap_mem[(a >> 2) % HEAP_WORDS];
   endfunction

   function automatic void wr(int unsigned a, int unsigned v);
      heap_mem[(a >> 2) % HEAP_WORDS] = v;
   endfunction

   function automatic int unsigned blk_size(int unsigned bp);
      return rd(bp - 4) & ~32'd7;
   endfunction

   function automatic int unsigned blk_next(int unsigned bp);
      return bp + blk_size(bp);
   endfunction

   function automatic int unsigned blk_prev(int unsigned bp);
      return bp - (rd(bp - 8) & ~32'd7);
   endfunction

   function automatic int unsigned blk_ftr(int unsigned bp);
      return bp + blk_size(bp) - 8;
   endfunction

   function automatic void set_tags(int unsigned bp, int unsigned sz, int unsigned al);
      wr(bp - 4, sz | al);
      wr(bp + sz - 8, sz | al);
   endfunction

   // Removes a block from the doubly linked free list.
   function automatic void unlink(int unsigned bp);
      int unsigned s;
      int unsigned p;
      s = rd(bp);
      p = rd(bp + 4);
      wr(bp, 0);
      wr(bp + 4, 0);
      if (p == 0) begin
         if (s != 0) wr(s + 4, 0);
         list_head = s;
      end else begin
         wr(p, s);
         if (s != 0) wr(s + 4, p);
      end
   endfunction

   function automatic void push_front(int unsigned bp);
      if (list_head == 0) begin
         list_head = bp;
         return;
      end
      wr(bp, list_head);
      wr(bp + 4, 0);
      wr(list_head + 4, bp);
      list_head = bp;
   endfunction

   // Joins a freed block with free neighbors on either side.
   function automatic int unsigned coalesce(int unsigned bp_in);
      int unsigned bp;
      int unsigned pa;
      int unsigned na;
      int unsigned sz;
      int unsigned p;
      int unsigned n;
      bp = bp_in;
      pa = rd(blk_ftr(blk_prev(bp))) & 1;
      na = rd(blk_next(bp) - 4) & 1;
      sz = blk_size(bp);
      if (pa != 0 && na == 0) begin
         n = blk_next(bp);
         unlink(n);
         sz += blk_size(n);
         set_tags(bp, sz, 0);
      end else if (pa == 0 && na != 0) begin
         p = blk_prev(bp);
         unlink(p);
         sz += blk_size(p);
         wr(blk_ftr(bp), sz);
         wr(p - 4, sz);
         bp = p;
      end else if (pa == 0 && na == 0) begin
         p = blk_prev(bp);
         n = blk_next(bp);
         unlink(p);
         unlink(n);
         sz += blk_size(p) + (rd(blk_ftr(n)) & ~32'd7);
         wr(p - 4, sz);
         wr(blk_ftr(n), sz);
         bp = p;
      end
      if (rover_ofs > bp && rover_ofs < blk_next(bp)) rover_ofs = bp;
      return bp;
   endfunction

   // Extends the break by a fresh free block; zero when the heap is full.
   function automatic int unsigned grow_heap(int unsigned bytes);
      int unsigned bp;
      bp = brk_ofs;
      if (longint'(brk_ofs) + longint'(bytes) > longint'(HEAP_WORDS) * 4) return 0;
      brk_ofs += bytes;
      wr(bp - 4, bytes);
      wr(bp + bytes - 8, bytes);
      wr(bp + bytes - 4, 1);
      wr(bp, 0);
      wr(bp + 4, 0);
      bp = coalesce(bp);
      push_front(bp);
      return bp;
   endfunction

   function automatic int unsigned walk_list(int unsigned start, int unsigned asize);
      int unsigned steps;
      int unsigned hit;
      steps = 0;
      rover_ofs = start;
      while (rover_ofs != 0) begin
         steps++;
         if (steps > WALK_MAX) begin
            rover_ofs = 0;
            return 0;
         end
         if (asize <= blk_size(rover_ofs)) begin
            hit = rover_ofs;
            rover_ofs = rd(rover_ofs);
            return hit;
         end
         rover_ofs = rd(rover_ofs);
      end
      return 0;
   endfunction

   function automatic int unsigned next_fit_search(int unsigned asize);
      int unsigned hit;
      if (rover_ofs == 0) rover_ofs = list_head;
      hit = walk_list(rover_ofs, asize);
      if (hit != 0) return hit;
      return walk_list(list_head, asize);
   endfunction

   function automatic void place(int unsigned bp, int unsigned asize);
      int unsigned csize;
      int unsigned r;
      csize = blk_size(bp);
      unlink(bp);
      if (csize - asize >= 16 && csize >= asize) begin
         set_tags(bp, asize, 1);
         r = blk_next(bp);
         set_tags(r, csize - asize, 0);
         wr(r, 0);
         wr(r + 4, 0);
         r = coalesce(r);
         push_front(r);
      end else begin
         set_tags(bp, csize, 1);
      end
   endfunction

   function automatic void init_heap();
      int unsigned init_sz;
      foreach (heap_mem[i]) heap_mem[i] = 0;
      heap_mem[1] = 9;
      heap_mem[2] = 9;
      heap_mem[3] = 1;
      chunk_min = CHUNK_RESET;
      brk_ofs   = 16;
      list_head = 0;
      rover_ofs = 0;
      init_sz   = 4096;
      if (16 + init_sz > HEAP_WORDS * 4) init_sz = (HEAP_WORDS * 4 - 16) & ~32'd7;
      void'(grow_heap(init_sz));
   endfunction

   // Applies one request word to the shadow heap and returns its result word.
   function automatic rsp_type predict_result(req_type rq);
      rsp_type     res;
      int unsigned asize;
      int unsigned bp;
      int unsigned ext;
      int unsigned words;
      int unsigned addr;
      res.payload_addr = 0;
      res.status       = ST_DONE;
      addr             = rq.block_addr;
      if (rq.func == FUNC_ALLOC) begin
         if (rq.req_size == 0) begin
            res.status = ST_ZERO;
         end else begin
            asize = (rq.req_size <= 8) ? 16 : 8 * ((int'(rq.req_size) + 15) / 8);
            bp = next_fit_search(asize);
            if (bp == 0) begin
               ext   = (asize > chunk_min) ? asize : chunk_min;
               words = ext / 4;
               bp    = grow_heap(words[0] ? (words + 1) * 4 : words * 4);
            end
            if (bp == 0) begin
               res.status = ST_OOM;
            end else begin
               place(bp, asize);
               res.payload_addr = bp[15:0];
            end
         end
      end else if (addr == 0) begin
         res.status = ST_NULL;
      end else begin
         set_tags(addr, blk_size(addr), 0);
         wr(addr, 0);
         wr(addr + 4, 0);
         push_front(coalesce(addr));
      end
      return res;
   endfunction

   // Follows every handshake, predicts on requests and compares on results.
   always @(posedge clock) begin
      rsp_type want;
      int      errs;
      errs = 0;
      if (reset) begin
         init_heap();
         expected_rsp.delete();
         fail_count <= 0;
         end_seen   <= 0;
      end else begin
         if (csr_valid && csr_ready) chunk_min = csr_wdata;
         if (req_valid && req_ready) expected_rsp.push_back(predict_result(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               if (fail_count + errs < 10)
                  $display("unexpected result word: addr %0d status %0d",
                           rsp_data.payload_addr, rsp_data.status);
               errs++;
            end else begin
               want = expected_rsp.pop_front();
               if (want.payload_addr !== rsp_data.payload_addr ||
                   want.status !== rsp_data.status) begin
                  if (fail_count + errs < 10)
                     $display("result mismatch: expected addr %0d status %0d, got addr %0d status %0d",
                              want.payload_addr, want.status,
                              rsp_data.payload_addr, rsp_data.status);
                  errs++;
               end
            end
         end
         // Anything still owed at the end of the run is a failure.
         if (end_check && !end_seen) begin
            end_seen <= 1;
            if (expected_rsp.size() != 0) begin
               $display("%0d result words never arrived", expected_rsp.size());
               errs++;
            end
         end
         fail_count <= fail_count + errs;
      end
   end

endmodule

@@ verif/tb_top.sv @@
// Top of the allocator testbench: clock, reset, request and register stimulus.
// Depends on efla_pkg, the allocator top level and heap_alloc_checker.
`timescale 1ns / 1ps

module tb_top;
   import efla_pkg::*;

   localparam int IDLE_LIMIT = 100000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   rsp_type     rsp_data;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [16:0] csr_wdata = '0;
   logic        end_check = 0;
   int          fail_count;

   int          words_sent = 0;
   int          words_back = 0;
   int          idle_cycles = 0;
   bit          func_sent [$];
   int unsigned live_blocks [$];
   bit          no_idle = 0;
   bit          hold_rsp = 0;

   explicit_free_list_heap_allocator_top dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_valid, .csr_ready, .csr_wdata
   );

   heap_alloc_checker chk (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_valid, .csr_ready, .csr_wdata,
      .end_check, .fail_count
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // Remembers the payloads handed out so releases can target live blocks.
   always @(posedge clock) begin
      bit was_free;
      if (!reset && rsp_valid && rsp_ready) begin
         was_free = func_sent.pop_front();
         if (was_free == FUNC_ALLOC && rsp_data.status == ST_DONE)
            live_blocks.push_back(rsp_data.payload_addr);
         words_back <= words_back + 1;
      end
   end

   // Ends the run when no channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Receiver: random stalls per word, and one long hold on request.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         gap = no_idle ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_word(bit fn, int unsigned sz, int unsigned addr);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= '{func: fn, req_size: sz[15:0], block_addr: addr[15:0]};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      func_sent.push_back(fn);
      words_sent++;
   endtask

   // Waits until every word sent has come back.
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (words_back != words_sent) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_chunk(logic [16:0] v);
      csr_valid <= 1;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
   endtask

   task automatic release_live(int idx);
      int unsigned a;
      a = live_blocks[idx];
      live_blocks.delete(idx);
      send_word(FUNC_FREE, $urandom, a);
   endtask

   // Mostly small sizes, some large ones that force growth or exhaustion.
   function automatic int unsigned pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 256);
      if (r < 90) return $urandom_range(257, 4096);
      if (r < 98) return $urandom_range(0, 65535);
      return 0;
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if (live_blocks.size() > 0 &&
             $urandom_range(0, 99) < (live_blocks.size() > 40 ? 70 : 40))
            release_live($urandom_range(0, live_blocks.size() - 1));
         else
            send_word(FUNC_ALLOC, pick_size(), $urandom);
      end
      no_idle = 0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      while (!req_ready) @(posedge clock);

      // Directed part: boundary sizes, exhaustion, null release, coalescing.
      send_word(FUNC_ALLOC, 0, 16'hFFFF);
      send_word(FUNC_ALLOC, 1, 0);
      send_word(FUNC_ALLOC, 8, 0);
      send_word(FUNC_ALLOC, 9, 0);
      send_word(FUNC_ALLOC, 24, 0);
      send_word(FUNC_ALLOC, 100, 0);
      send_word(FUNC_ALLOC, 4000, 0);
      send_word(FUNC_ALLOC, 8000, 0);
      send_word(FUNC_ALLOC, 65535, 0);
      send_word(FUNC_FREE, 16'hFFFF, 0);
      drain();
      release_live(0);
      release_live(1);
      release_live(0);
      send_word(FUNC_ALLOC, 200, 0);
      send_word(FUNC_ALLOC, 4, 0);
      drain();

      // Tiny and odd growth sizes.
      write_chunk(17'd8);
      random_phase(200);
      drain();
      write_chunk(17'd13);
      random_phase(150);

      // Long receiver hold while requests keep coming.
      hold_rsp = 1;
      random_phase(100);
      drain();

      // A growth size of 65536 bytes, then a random multiple of eight.
      write_chunk(17'd65536);
      random_phase(200);
      drain();
      write_chunk(17'($urandom_range(1, 8192) * 8));
      random_phase(190);
      drain();

      // Releases of arbitrary offsets, then a few more allocations.
      for (int i = 0; i < 8; i++) send_word(FUNC_FREE, $urandom, $urandom_range(1, 65535));
      for (int i = 0; i < 6; i++) send_word(FUNC_ALLOC, pick_size(), $urandom);
      drain();

      repeat (100) @(posedge clock);
      end_check <= 1;
      repeat (2) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
